/* rtl/tdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared constants for the factorizer and its bit-serial divider.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int NUMBER_BITS = 31;
  localparam int EXP_BITS    = 5;
  localparam int MAX_RESULTS = 9;
  localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

endpackage

/* rtl/tdf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder are held
// until the next start.
// ----------------------------------------------------------------------------
module tdf_div #(
  parameter int WIDTH = tdf_pkg::NUMBER_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);

  localparam int CNT_BITS = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]    quo_r, quo_nxt;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0]    div_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [WIDTH:0]      trial;
  logic                ge;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WIDTH-2:0], ge};
      rem_nxt = ge ? WIDTH'(trial - {1'b0, div_r}) : WIDTH'(trial);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/trial_division_factorizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer
// Splits an integer into primes by trial division and emits one word per
// distinct prime in ascending order, with its exponent (at most MAX_RESULTS).
// ----------------------------------------------------------------------------
// Zero and one give a single word with exponent zero. Each trial division runs
// through the bit-serial divider, and every repeated division while a factor
// is stripped runs through it again. The worst case is a prime close to 2^31,
// which tries every odd divisor up to its square root; the largest power of
// two needs a single division. One item is in work at a time.
// Reset clears the control state; no clearing pass is needed.
module trial_division_factorizer #(
  parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [((NUMBER_BITS+7)/8)*8-1:0] in_tdata,   // number
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [((NUMBER_BITS+tdf_pkg::EXP_BITS+7)/8)*8-1:0] out_tdata, // prime, exponent
  output logic                           out_tlast
);

  localparam int NB = NUMBER_BITS;
  localparam int EB = tdf_pkg::EXP_BITS;
  localparam int KB = tdf_pkg::RES_BITS;

  localparam logic [KB-1:0] K_LAST = KB'(tdf_pkg::MAX_RESULTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TWOS  = 6'b000010,
    S_START = 6'b000100,
    S_WAIT  = 6'b001000,
    S_CHECK = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NB-1:0] n_r, n_nxt;
  logic [NB-1:0] d_r, d_nxt;
  logic [EB-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [KB-1:0] k_r, k_nxt;
  logic          first_r, first_nxt;
  logic          tail_r, tail_nxt;
  logic [NB-1:0] pend_prime_r, pend_prime_nxt;
  logic [EB-1:0] pend_exp_r, pend_exp_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [NB-1:0] out_prime_r, out_prime_nxt;
  logic [EB-1:0] out_exp_r, out_exp_nxt;
  logic          out_last_r, out_last_nxt;

  logic [NB-1:0] in_num;
  logic          in_fire;
  logic          out_free;
  logic          prod_ok;
  logic          prod_fire;
  logic [NB-1:0] prod_prime;
  logic [EB-1:0] prod_exp;
  logic          div_start;
  logic          div_done;
  logic [NB-1:0] div_quot;
  logic [NB-1:0] div_rem;

  tdf_div #(
    .WIDTH (NB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_num    = in_tdata[NB-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign prod_ok   = !pend_v_r || out_free;
  assign cnt_inc   = (cnt_r == tdf_pkg::EXP_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    first_nxt      = first_r;
    tail_nxt       = tail_r;
    pend_prime_nxt = pend_prime_r;
    pend_exp_nxt   = pend_exp_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_prime_nxt  = out_prime_r;
    out_exp_nxt    = out_exp_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    prod_fire      = 1'b0;
    prod_prime     = d_r;
    prod_exp       = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt    = in_num;
          cnt_nxt  = '0;
          k_nxt    = '0;
          tail_nxt = 1'b0;
          if (in_num[NB-1:1] == '0) begin
            pend_prime_nxt = in_num;
            pend_exp_nxt   = '0;
            pend_v_nxt     = 1'b1;
            state_nxt      = S_FLUSH;
          end else begin
            state_nxt = S_TWOS;
          end
        end
      end
      S_TWOS: begin
        prod_prime = NB'(2);
        if (!n_r[0]) begin
          n_nxt   = n_r >> 1;
          cnt_nxt = cnt_inc;
        end else if (cnt_r == '0 || prod_ok) begin
          prod_fire = (cnt_r != '0);
          d_nxt     = NB'(3);
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = (prod_fire && k_r == K_LAST) ? S_FLUSH : S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (tail_r) begin
          prod_prime = n_r;
          prod_exp   = EB'(1);
          if (n_r[NB-1:1] == '0) begin
            state_nxt = S_FLUSH;
          end else if (prod_ok) begin
            prod_fire = 1'b1;
            state_nxt = S_FLUSH;
          end
        end else if (first_r && d_r > div_quot) begin
          tail_nxt = 1'b1;
        end else if (div_rem == '0) begin
          n_nxt     = div_quot;
          cnt_nxt   = cnt_inc;
          first_nxt = 1'b0;
          state_nxt = S_START;
        end else if (cnt_r == '0 || prod_ok) begin
          prod_fire = (cnt_r != '0);
          d_nxt     = d_r + NB'(2);
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = (prod_fire && k_r == K_LAST) ? S_FLUSH : S_START;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = pend_prime_r;
          out_exp_nxt   = pend_exp_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (prod_fire) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_prime_nxt = pend_prime_r;
        out_exp_nxt   = pend_exp_r;
        out_last_nxt  = 1'b0;
      end
      pend_prime_nxt = prod_prime;
      pend_exp_nxt   = prod_exp;
      pend_v_nxt     = 1'b1;
      k_nxt          = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      tail_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      tail_r      <= tail_nxt;
    end
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    pend_prime_r <= pend_prime_nxt;
    pend_exp_r   <= pend_exp_nxt;
    out_prime_r  <= out_prime_nxt;
    out_exp_r    <= out_exp_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    out_tdata           = '0;
    out_tdata[NB-1:0]   = out_prime_r;
    out_tdata[NB+EB-1:NB] = out_exp_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending result left over in idle");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |-> pend_v_r)
    else $error("flush without a pending result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= KB'(tdf_pkg::MAX_RESULTS))
    else $error("result count beyond limit");

  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> d_r[0])
    else $error("even trial divisor");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT)
    else $error("divider finished outside of wait");
`endif

endmodule

/* dv/tb_trial_division_factorizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer testbench
// Streams numbers into the factorizer and checks every prime/exponent word
// against a local trial division predictor. The directed set covers zero,
// one, the widest value, the largest exponent and the most distinct primes.
// Random numbers are mostly cheap to factor so that the run stays short.
// Both sides idle and stall at random, and one long output stall backs the
// block up.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer;

  localparam int IN_W  = ((tdf_pkg::NUMBER_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((tdf_pkg::NUMBER_BITS + tdf_pkg::EXP_BITS + 7) / 8) * 8;
  localparam longint unsigned NUMBER_LIMIT = 64'd1 << tdf_pkg::NUMBER_BITS;
  localparam int RANDOM_NUMBERS = 100;
  localparam int LONG_HOLD_CYCLES = 500;

  typedef struct packed {
    logic [tdf_pkg::NUMBER_BITS-1:0] prime;
    logic [tdf_pkg::EXP_BITS-1:0]    exponent;
    logic                            last;
  } factor_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  logic [IN_W-1:0] numbers_to_send[$];
  factor_t         expected_factors[$];
  int              numbers_total = 0;
  int              numbers_accepted = 0;
  int              factors_seen = 0;
  int              mismatches = 0;
  bit              number_taken = 1'b0;
  int              burst_left = 1;
  int              gap_left = 0;
  int              stall_mode = 0;
  int              mode_left = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  factor_t         got_factor;
  factor_t         want_factor;

  trial_division_factorizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic factor_t make_factor(longint unsigned p, int unsigned e);
    factor_t f;
    f.prime    = p[tdf_pkg::NUMBER_BITS-1:0];
    f.exponent = (e > tdf_pkg::EXP_MAX) ? tdf_pkg::EXP_MAX : e[tdf_pkg::EXP_BITS-1:0];
    f.last     = 1'b0;
    return f;
  endfunction

  // Trial division on the masked number, queuing one word per distinct prime.
  function automatic void predict_factors(logic [IN_W-1:0] word);
    longint unsigned n;
    longint unsigned d;
    int unsigned     e;
    factor_t         found[$];
    n = word[tdf_pkg::NUMBER_BITS-1:0];
    if (n <= 1) begin
      found.insert(found.size(), make_factor(n, 0));
    end else begin
      e = 0;
      while (n % 2 == 0) begin
        n = n / 2;
        e++;
      end
      if (e != 0) found.insert(found.size(), make_factor(2, e));
      for (d = 3; found.size() < tdf_pkg::MAX_RESULTS && d <= n / d; d += 2) begin
        e = 0;
        while (n % d == 0) begin
          n = n / d;
          e++;
        end
        if (e != 0) found.insert(found.size(), make_factor(d, e));
      end
      if (found.size() < tdf_pkg::MAX_RESULTS && n > 1) begin
        found.insert(found.size(), make_factor(n, 1));
      end
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_factors.insert(expected_factors.size(), found[i]);
  endfunction

  // Mostly numbers that factor quickly; a few need a longer divisor search.
  function automatic logic [tdf_pkg::NUMBER_BITS-1:0] pick_number();
    int unsigned small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    longint unsigned n;
    longint unsigned p;
    int              kind;
    int              shift;
    kind = $urandom_range(0, 99);
    n = 1;
    if (kind < 35) begin
      repeat ($urandom_range(1, 14)) begin
        p = small_primes[$urandom_range(0, 14)];
        if (n * p < NUMBER_LIMIT) n = n * p;
      end
    end else if (kind < 70) begin
      n = $urandom_range(1, 65535);
    end else if (kind < 85) begin
      n = $urandom_range(1, 4095) | 1;
      shift = $urandom_range(0, tdf_pkg::NUMBER_BITS - 1);
      while ((n << shift) >= NUMBER_LIMIT) shift--;
      n = n << shift;
    end else if (kind < 97) begin
      n = $urandom_range(2, 255);
    end else begin
      n = $urandom_range(1, 1 << 22);
    end
    return n[tdf_pkg::NUMBER_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_factors(in_tdata);
      numbers_accepted++;
      number_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || number_taken) begin
      number_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (numbers_to_send.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= numbers_to_send.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && factors_seen >= 30) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      factors_seen++;
      got_factor.prime    = out_tdata[tdf_pkg::NUMBER_BITS-1:0];
      got_factor.exponent = out_tdata[tdf_pkg::NUMBER_BITS +: tdf_pkg::EXP_BITS];
      got_factor.last     = out_tlast;
      if (expected_factors.size() == 0) begin
        mismatches++;
        $display("%t: unexpected word prime %0d exponent %0d last %0d", $realtime,
                 got_factor.prime, got_factor.exponent, got_factor.last);
      end else begin
        want_factor = expected_factors.pop_front();
        if (got_factor.prime !== want_factor.prime) begin
          mismatches++;
          $display("%t: prime expected %0d actual %0d", $realtime,
                   want_factor.prime, got_factor.prime);
        end
        if (got_factor.exponent !== want_factor.exponent) begin
          mismatches++;
          $display("%t: exponent expected %0d actual %0d", $realtime,
                   want_factor.exponent, got_factor.exponent);
        end
        if (got_factor.last !== want_factor.last) begin
          mismatches++;
          $display("%t: last expected %0d actual %0d", $realtime,
                   want_factor.last, got_factor.last);
        end
      end
    end
  end

  initial begin
    logic [IN_W-1:0] directed[$];
    directed = '{
      0, 1, 2, 3, 4, 9, 25, 49, 97, 360, 3072, 65537,
      63001,                    // square of the prime 251
      16777207,                 // 4093 * 4099
      223092870,                // the nine smallest primes
      1 << 30,                  // largest exponent
      1162261467,               // 3 ** 19
      2147483646,
      2147483647,               // widest value, a prime
      {1'b1, 31'd12}            // padding bit set above the number
    };
    foreach (directed[i]) numbers_to_send.insert(numbers_to_send.size(), directed[i]);
    repeat (RANDOM_NUMBERS) begin
      numbers_to_send.insert(numbers_to_send.size(), IN_W'(pick_number()));
    end
    numbers_total = numbers_to_send.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (numbers_accepted < numbers_total) @(posedge clk);
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
